[rtl/core/bounded_random_generator_macros.svh]
// Assertion macros for the bounded random generator.
// Assumes clk_i and rst_ni are visible at the point of use.
`ifndef BOUNDED_RANDOM_GENERATOR_MACROS_SVH
`define BOUNDED_RANDOM_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BRG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/brg_pkg.sv]
// Shared constants and types for the bounded random generator.
// No dependencies.
package brg_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [DataW-1:0] GoldenStep = 32'h9E37_79B9;
  localparam logic [DataW-1:0] MixMulA    = 32'h21F0_AAAD;
  localparam logic [DataW-1:0] MixMulB    = 32'h735A_2D97;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] rem;
  } brg_mod_rsp_t;

endpackage

[rtl/core/brg_mod_unit.sv]
// Iterative 32-bit remainder unit, one restoring step per cycle.
// Depends on brg_pkg.
module brg_mod_unit import brg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output brg_mod_rsp_t     rsp_o
);

  localparam int unsigned CntW = $clog2(DataW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] dvd_q, dvd_d;
  logic [DataW-1:0] dvs_q, dvs_d;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;

  assign trial = {rem_q, dvd_q[DataW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = diff[DataW] ? trial[DataW-1:0] : diff[DataW-1:0];
      dvd_d = {dvd_q[DataW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

[rtl/core/bounded_random_generator.sv]
// Bounded random generator: one request in, one result out. A request takes one
// or more draws (usually 1, fewer than 2 on average); each draw passes through
// the mixer states DRAW, MULA, MULB and MIXF, which run the two multiplies
// through one shared 32x32 multiplier, and then waits in MOD for the
// bit-serial remainder unit. The input is ready again in the same cycle that
// the result appears at the output. A full-range request takes the mixer
// output directly and skips the remainder unit, and a request with its bounds
// out of order goes straight to the done state. The input is not ready while
// a request is in progress; the output register lets the next request start
// while a result waits, and a finished request waits until that register is
// free. Writing the seed loads the counter and must happen while the block
// is idle.
// Depends on brg_pkg, brg_mod_unit and bounded_random_generator_macros.svh.
`include "bounded_random_generator_macros.svh"

module bounded_random_generator import brg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             seed_we_i,
  input  logic [DataW-1:0] seed_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [DataW-1:0] low_bound_i,
  input  logic [DataW-1:0] high_bound_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] value_o,
  output logic             bad_bounds_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DRAW = 3'd1;
  localparam logic [2:0] S_MULA = 3'd2;
  localparam logic [2:0] S_MULB = 3'd3;
  localparam logic [2:0] S_MIXF = 3'd4;
  localparam logic [2:0] S_MOD  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [DataW-1:0] weyl_q, weyl_d;
  logic [DataW-1:0] mix_q, mix_d;
  logic [DataW-1:0] lo_q, lo_d;
  logic [DataW-1:0] range_q, range_d;
  logic             full_q, full_d;
  logic [DataW-1:0] res_q, res_d;
  logic             res_bad_q, res_bad_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] value_q, value_d;
  logic             bad_q, bad_d;

  logic [DataW-1:0] mul_op;
  logic [DataW-1:0] mul_k;
  logic [DataW-1:0] prod;
  logic [DataW-1:0] mix_fin;
  logic [DataW-1:0] accept_diff;
  logic [DataW-1:0] accept_lim;
  logic             mod_start;
  brg_mod_rsp_t     mod_rsp;
  logic             in_xfer;

  assign in_xfer = in_valid_i && in_ready_o;

  // shared multiplier
  assign mul_op  = (state_q == S_MULA) ? mix_q : (mix_q ^ (mix_q >> 15));
  assign mul_k   = (state_q == S_MULA) ? MixMulA : MixMulB;
  assign prod    = mul_op * mul_k;
  assign mix_fin = mix_q ^ (mix_q >> 15);

  assign accept_diff = mix_q - mod_rsp.rem;
  assign accept_lim  = '0 - range_q;

  brg_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mix_fin),
    .divisor_i  (range_q),
    .rsp_o      (mod_rsp)
  );

  always_comb begin
    state_d     = state_q;
    weyl_d      = weyl_q;
    mix_d       = mix_q;
    lo_d        = lo_q;
    range_d     = range_q;
    full_d      = full_q;
    res_d       = res_q;
    res_bad_d   = res_bad_q;
    out_valid_d = out_valid_q;
    value_d     = value_q;
    bad_d       = bad_q;
    mod_start   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          lo_d    = low_bound_i;
          range_d = high_bound_i - low_bound_i + 1'b1;
          full_d  = (low_bound_i == '0) && (high_bound_i == '1);
          if (low_bound_i > high_bound_i) begin
            res_d     = '0;
            res_bad_d = 1'b1;
            state_d   = S_DONE;
          end else begin
            res_bad_d = 1'b0;
            state_d   = S_DRAW;
          end
        end
      end
      S_DRAW: begin
        mix_d   = weyl_q ^ (weyl_q >> 16);
        weyl_d  = weyl_q + GoldenStep;
        state_d = S_MULA;
      end
      S_MULA: begin
        mix_d   = prod;
        state_d = S_MULB;
      end
      S_MULB: begin
        mix_d   = prod;
        state_d = S_MIXF;
      end
      S_MIXF: begin
        mix_d = mix_fin;
        if (full_q) begin
          res_d   = mix_fin;
          state_d = S_DONE;
        end else begin
          mod_start = 1'b1;
          state_d   = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_rsp.done) begin
          if (accept_diff > accept_lim) begin
            state_d = S_DRAW;
          end else begin
            res_d   = lo_q + mod_rsp.rem;
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          value_d     = res_q;
          bad_d       = res_bad_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (seed_we_i) begin
      weyl_d = seed_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      weyl_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      weyl_q      <= weyl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mix_q     <= mix_d;
    lo_q      <= lo_d;
    range_q   <= range_d;
    full_q    <= full_d;
    res_q     <= res_d;
    res_bad_q <= res_bad_d;
    value_q   <= value_d;
    bad_q     <= bad_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign bad_bounds_o = bad_q;

  `BRG_ASSERT_NOW(a_bad_value_zero, out_valid_o && bad_bounds_o, value_o == '0, "bad bounds with nonzero value")
  `BRG_ASSERT_NOW(a_mod_done_in_mod, mod_rsp.done, state_q == S_MOD, "remainder done outside wait state")
  `BRG_ASSERT_NOW(a_rem_in_range, mod_rsp.done, mod_rsp.rem < range_q, "remainder not below range")
  `BRG_ASSERT_NEXT(a_bad_keeps_weyl, in_xfer && !seed_we_i && (low_bound_i > high_bound_i), weyl_q == $past(weyl_q), "counter moved on bad bounds")

endmodule

[bench/bounded_random_generator_tb.sv]
// Self-checking bench for bounded_random_generator: bound pairs in, bounded draws out,
// checked against an in-bench splitmix32 debiased-modulo predictor across seed settings.
// Depends on brg_pkg and the bounded_random_generator RTL.
`timescale 1ns / 1ps

module bounded_random_generator_tb;
  import brg_pkg::*;

  typedef struct {
    logic [DataW-1:0] lo;
    logic [DataW-1:0] hi;
  } bound_pair_t;

  typedef struct {
    logic [DataW-1:0] value;
    logic             bad;
  } draw_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             seed_we_i    = 1'b0;
  logic [DataW-1:0] seed_i       = '0;
  logic             in_valid_i   = 1'b0;
  logic             in_ready_o;
  logic [DataW-1:0] low_bound_i  = '0;
  logic [DataW-1:0] high_bound_i = '0;
  logic             out_valid_o;
  logic             out_ready_i  = 1'b0;
  logic [DataW-1:0] value_o;
  logic             bad_bounds_o;

  bound_pair_t      pending_bounds_q[$];
  draw_t            expected_draws_q[$];
  logic [DataW-1:0] weyl_state = '0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               error_count = 0;

  bounded_random_generator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_we_i   (seed_we_i),
    .seed_i      (seed_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .low_bound_i (low_bound_i),
    .high_bound_i(high_bound_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .bad_bounds_o(bad_bounds_o)
  );

  function automatic logic [DataW-1:0] splitmix(input logic [DataW-1:0] w);
    logic [DataW-1:0] x;
    x = w ^ (w >> 16);
    x = x * MixMulA;
    x = x ^ (x >> 15);
    x = x * MixMulB;
    x = x ^ (x >> 15);
    return x;
  endfunction

  // Advances weyl_state once per attempt, including rejected ones.
  function automatic draw_t predict_draw(input logic [DataW-1:0] lo, input logic [DataW-1:0] hi);
    draw_t       d;
    logic [32:0] span;
    logic [32:0] mixed;
    logic [32:0] rem;
    d.value = '0;
    d.bad   = 1'b0;
    if (lo > hi) begin
      d.bad = 1'b1;
      return d;
    end
    span = {1'b0, hi} - {1'b0, lo} + 33'd1;
    if (span[32]) begin
      d.value    = splitmix(weyl_state);
      weyl_state = weyl_state + GoldenStep;
      return d;
    end
    do begin
      mixed      = {1'b0, splitmix(weyl_state)};
      weyl_state = weyl_state + GoldenStep;
      rem        = mixed % span;
    end while (mixed - rem > 33'h1_0000_0000 - span);
    d.value = lo + rem[DataW-1:0];
    return d;
  endfunction

  function automatic bound_pair_t random_bounds();
    bound_pair_t      p;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    int               kind;
    a    = $urandom;
    b    = $urandom;
    kind = $urandom_range(99, 0);
    if (kind < 10) begin
      p.lo = a;
      p.hi = b;
    end else if (kind < 20) begin
      if (a == b) b = a ^ 32'h1;
      p.lo = (a > b) ? a : b;
      p.hi = (a > b) ? b : a;
    end else if (kind < 50) begin
      b    = $urandom_range(1000, 0);
      p.lo = a;
      p.hi = (a > 32'hFFFF_FFFF - b) ? 32'hFFFF_FFFF : a + b;
    end else if (kind < 65) begin
      // spans above 2^31, up to 2^31 + 2^30, reject often
      p.lo = $urandom_range(32'h3FFF_FFFF, 0);
      p.hi = p.lo + 32'h8000_0000 + $urandom_range(32'h3FFF_FFFF, 0);
    end else if (kind < 75) begin
      p.lo = $urandom_range(1, 0);
      p.hi = 32'hFFFF_FFFF - $urandom_range(1, 0);
    end else if (kind < 85) begin
      p.lo = a;
      p.hi = a;
    end else begin
      p.lo = (a < b) ? a : b;
      p.hi = (a < b) ? b : a;
    end
    return p;
  endfunction

  task automatic push_bounds(input logic [DataW-1:0] lo, input logic [DataW-1:0] hi);
    bound_pair_t p;
    p.lo = lo;
    p.hi = hi;
    pending_bounds_q.push_back(p);
  endtask

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("tb: %0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic wait_for_drain();
    while (pending_bounds_q.size() != 0 || in_valid_i || expected_draws_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_seed(input logic [DataW-1:0] value);
    @(posedge clk_i);
    seed_we_i <= 1'b1;
    seed_i    <= value;
    @(posedge clk_i);
    seed_we_i <= 1'b0;
    weyl_state = value;
  endtask

  task automatic run_random_phase(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) pending_bounds_q.push_back(random_bounds());
  endtask

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    bound_pair_t p;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_draws_q.push_back(predict_draw(low_bound_i, high_bound_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_bounds_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          p = pending_bounds_q.pop_front();
          in_valid_i   <= 1'b1;
          low_bound_i  <= p.lo;
          high_bound_i <= p.hi;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    draw_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_draws_q.size() == 0) begin
          report_mismatch("unexpected transfer", value_o, '0);
        end else begin
          want = expected_draws_q.pop_front();
          if (value_o !== want.value) report_mismatch("value", value_o, want.value);
          if (bad_bounds_o !== want.bad) begin
            report_mismatch("bad_bounds", DataW'(bad_bounds_o), DataW'(want.bad));
          end
        end
      end
      out_ready_i <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  initial begin
    #4ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_seed(32'hFFFF_FFFF);

    send_idle_pct = 35;
    recv_idle_pct = 54;
    push_bounds(32'h0000_0000, 32'hFFFF_FFFF);
    push_bounds(32'h0000_0001, 32'h0000_0000);
    push_bounds(32'hFFFF_FFFF, 32'h0000_0000);
    push_bounds(32'h8000_0000, 32'h7FFF_FFFF);
    push_bounds(32'h0000_0000, 32'h0000_0000);
    push_bounds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_bounds(32'h1234_5678, 32'h1234_5678);
    push_bounds(32'h0000_0000, 32'h0000_0001);
    push_bounds(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    push_bounds(32'h0000_0000, 32'h7FFF_FFFF);
    push_bounds(32'h0000_0000, 32'h8000_0000);
    push_bounds(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_bounds(32'h0000_0000, 32'hFFFF_FFFE);
    push_bounds(32'h0000_0001, 32'hFFFF_FFFF);
    push_bounds(32'h0000_0005, 32'h0000_000A);
    push_bounds(32'hAAAA_AAAA, 32'hD555_5555);
    push_bounds(32'h5555_5555, 32'hAAAA_AAAA);
    push_bounds(32'h0000_0000, 32'hFFFF_FFFF);
    run_random_phase(544, 35, 54);
    wait_for_drain();

    write_seed(32'h0000_0000);
    run_random_phase(544, 54, 35);
    wait_for_drain();

    write_seed($urandom);
    run_random_phase(544, 0, 0);
    wait_for_drain();

    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/brg_pkg.sv
rtl/core/brg_mod_unit.sv
rtl/core/bounded_random_generator.sv
bench/bounded_random_generator_tb.sv
